### rtl/core/hbt_pkg.sv
// Package for the hex/binary text-to-bytes converter.
// Holds payload and queue-entry structs, mode/phase/error codes and command text.
// No dependencies.
package hbt_pkg;

  // Queue depth between the front and back sections.
  localparam int unsigned QueueDepth = 4;

  // Mode codes, as written to the start_mode register.
  typedef enum logic [1:0] {
    MD_HEX    = 2'd0,
    MD_BIN    = 2'd1,
    MD_HEX_LE = 2'd2,
    MD_BIN_LE = 2'd3
  } hbt_mode_e;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_COMMENT = 2'd1,
    PH_COMMAND = 2'd2
  } hbt_phase_e;

  // Error kinds.
  typedef enum logic [1:0] {
    ERR_CMD_IN_BYTE = 2'd0,
    ERR_BAD_CMD     = 2'd1,
    ERR_BAD_CHAR    = 2'd2
  } hbt_err_e;

  // Characters of interest.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChLowB  = 8'h62;

  // Command text after the dot (long forms); character 0 sits in the top element.
  localparam logic [16:0][7:0] HexCmd = {"format hex", "_little"};
  localparam logic [19:0][7:0] BinCmd = {"format binary", "_little"};

  // Command lengths: short form (big mode) and long form (little mode).
  localparam logic [4:0] HexShortLen = 5'd10;
  localparam logic [4:0] HexLongLen  = 5'd17;
  localparam logic [4:0] BinShortLen = 5'd13;
  localparam logic [4:0] BinLongLen  = 5'd20;
  // Position where hex and binary commands diverge.
  localparam logic [4:0] CandPos     = 5'd7;

  // Input payload.
  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } hbt_in_t;

  // Output payload.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       error_flag;
    logic [1:0] error_kind;
    logic       stream_end;
  } hbt_out_t;

  // Character class, filled in by the front section.
  typedef struct packed {
    logic       is_ws;
    logic       is_nl;
    logic       is_dot;
    logic       is_semi;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       bin_ok;
  } hbt_class_t;

  // Queue entry.
  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    hbt_class_t cls;
  } hbt_item_t;

  // Queue status toward the back section.
  typedef struct packed {
    logic full;
    logic empty;
  } hbt_q_status_t;

  // Expected command character at a match position for a candidate.
  function automatic logic [7:0] cmd_char(logic cand, logic [4:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (cand) begin
      if (idx < BinLongLen) ch = BinCmd[5'(BinLongLen - 5'd1 - idx)];
    end else begin
      if (idx < HexLongLen) ch = HexCmd[5'(HexLongLen - 5'd1 - idx)];
    end
    return ch;
  endfunction

endpackage

### rtl/core/hbt_front.sv
// Front section: takes input characters and classifies them for the back section.
// Depends on hbt_pkg.
module hbt_front
  import hbt_pkg::*;
(
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hbt_in_t       in_data_i,
  input  hbt_q_status_t q_status_i,
  output logic          push_o,
  output hbt_item_t     item_o
);

  logic [7:0] ch;

  assign ch         = in_data_i.text_char;
  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  // Character classification
  always_comb begin
    item_o               = '0;
    item_o.text_char     = ch;
    item_o.last_char     = in_data_i.last_char;
    item_o.cls.is_nl     = (ch == ChNl);
    item_o.cls.is_ws     = (ch == ChSpace) || (ch == ChTab) || (ch == ChNl);
    item_o.cls.is_dot    = (ch == ChDot);
    item_o.cls.is_semi   = (ch == ChSemi);
    item_o.cls.bin_ok    = (ch == 8'h30) || (ch == 8'h31);
    if (ch >= 8'h30 && ch <= 8'h39) begin
      item_o.cls.hex_ok  = 1'b1;
      item_o.cls.hex_val = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      item_o.cls.hex_ok  = 1'b1;
      item_o.cls.hex_val = 4'(ch[2:0] + 3'd1) | 4'h8;  // a..f -> 10..15
    end
  end

endmodule

### rtl/core/hbt_queue.sv
// Short queue of classified characters between the front and back sections.
// Depends on hbt_pkg.
module hbt_queue
  import hbt_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hbt_item_t     item_i,
  input  logic          pop_i,
  output hbt_item_t     head_o,
  output hbt_q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hbt_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    if (do_push && !do_pop)      cnt_d = CntW'(cnt_q + 1'b1);
    else if (!do_push && do_pop) cnt_d = CntW'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

### rtl/core/hbt_back.sv
// Back section: parser state machine, byte packing, error latch and output register.
// Depends on hbt_pkg.
module hbt_back
  import hbt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [1:0]    cfg_data_i,
  input  hbt_item_t     head_i,
  input  hbt_q_status_t q_status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hbt_out_t      out_data_o
);

  hbt_mode_e  start_q, start_d;
  hbt_mode_e  mode_q, mode_d;
  hbt_phase_e phase_q, phase_d;
  logic [2:0] dpos_q, dpos_d;
  logic [7:0] pbyte_q, pbyte_d;
  logic [4:0] idx_q, idx_d;
  logic       cand_q, cand_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;
  hbt_out_t   out_data_q, out_data_d;

  // Step results for the head character
  hbt_mode_e  s_mode;
  hbt_phase_e s_phase;
  logic [2:0] s_dpos;
  logic [7:0] s_pbyte;
  logic [4:0] s_idx;
  logic       s_cand;
  logic       s_got;
  logic [7:0] s_byte;
  logic       s_err;
  hbt_err_e   s_kind;
  logic       s_emit;

  logic       do_plain;
  logic       cand_now;
  logic [4:0] short_len, long_len;
  logic [4:0] idx_inc;
  logic       hex_hi;
  logic [2:0] bit_pos;
  logic [7:0] nib_word;
  logic [7:0] bit_word;
  logic       last;
  logic [7:0] ch;

  assign pop_o       = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign last        = head_i.last_char;
  assign ch          = head_i.text_char;

  // Per-character parse step
  always_comb begin
    s_mode    = mode_q;
    s_phase   = phase_q;
    s_dpos    = dpos_q;
    s_pbyte   = pbyte_q;
    s_idx     = idx_q;
    s_cand    = cand_q;
    s_got     = 1'b0;
    s_byte    = 8'h00;
    s_err     = 1'b0;
    s_kind    = ERR_CMD_IN_BYTE;
    do_plain  = 1'b0;
    cand_now  = (idx_q == CandPos) ? (ch == ChLowB) : cand_q;
    short_len = cand_now ? BinShortLen : HexShortLen;
    long_len  = cand_now ? BinLongLen : HexLongLen;
    idx_inc   = 5'(idx_q + 5'd1);
    hex_hi    = 1'b0;
    bit_pos   = 3'd0;
    nib_word  = 8'h00;
    bit_word  = 8'h00;

    unique case (phase_q)
      PH_COMMENT: begin
        if (head_i.cls.is_nl) s_phase = PH_NORMAL;
      end
      PH_COMMAND: begin
        s_cand = cand_now;
        if (idx_q == short_len && ch != ChUnder) begin
          // Short form done: big mode, character goes on as text
          s_mode   = cand_now ? MD_BIN : MD_HEX;
          s_phase  = PH_NORMAL;
          s_idx    = '0;
          do_plain = 1'b1;
        end else if (idx_q < long_len && ch == cmd_char(cand_now, idx_q)) begin
          s_idx = idx_inc;
          if (idx_inc == long_len) begin
            s_mode  = cand_now ? MD_BIN_LE : MD_HEX_LE;
            s_phase = PH_NORMAL;
            s_idx   = '0;
          end
        end else begin
          s_err  = 1'b1;
          s_kind = (idx_q < short_len) ? ERR_BAD_CMD : ERR_BAD_CHAR;
        end
      end
      default: do_plain = 1'b1;
    endcase

    // Ordinary text
    if (do_plain) begin
      if (head_i.cls.is_ws) begin
        s_got = 1'b0;
      end else if (head_i.cls.is_dot) begin
        if (dpos_q != 3'd0) begin
          s_err  = 1'b1;
          s_kind = ERR_CMD_IN_BYTE;
        end else begin
          s_phase = PH_COMMAND;
          s_idx   = '0;
          s_cand  = 1'b0;
        end
      end else if (head_i.cls.is_semi) begin
        s_phase = PH_COMMENT;
      end else if (s_mode == MD_HEX || s_mode == MD_HEX_LE) begin
        if (!head_i.cls.hex_ok) begin
          s_err  = 1'b1;
          s_kind = ERR_BAD_CHAR;
        end else begin
          hex_hi   = (s_mode == MD_HEX) ? !dpos_q[0] : dpos_q[0];
          nib_word = hex_hi ? {head_i.cls.hex_val, 4'h0} : {4'h0, head_i.cls.hex_val};
          s_pbyte  = pbyte_q | nib_word;
          if (dpos_q[0]) begin
            s_got   = 1'b1;
            s_byte  = s_pbyte;
            s_pbyte = 8'h00;
            s_dpos  = 3'd0;
          end else begin
            s_dpos  = 3'd1;
          end
        end
      end else begin
        if (!head_i.cls.bin_ok) begin
          s_err  = 1'b1;
          s_kind = ERR_BAD_CHAR;
        end else begin
          bit_pos  = (s_mode == MD_BIN) ? 3'(3'd7 - dpos_q) : dpos_q;
          bit_word = 8'(ch[0]) << bit_pos;
          s_pbyte  = pbyte_q | bit_word;
          if (dpos_q == 3'd7) begin
            s_got   = 1'b1;
            s_byte  = s_pbyte;
            s_pbyte = 8'h00;
            s_dpos  = 3'd0;
          end else begin
            s_dpos  = 3'(dpos_q + 3'd1);
          end
        end
      end
    end

    // Text ends inside a command
    if (!s_err && last && s_phase == PH_COMMAND) begin
      if (s_idx == (s_cand ? BinShortLen : HexShortLen)) begin
        s_mode = s_cand ? MD_BIN : MD_HEX;
      end else begin
        s_err  = 1'b1;
        s_kind = (s_idx < (s_cand ? BinShortLen : HexShortLen)) ? ERR_BAD_CMD : ERR_BAD_CHAR;
      end
    end

    if (s_err) begin
      s_got  = 1'b0;
      s_byte = 8'h00;
    end

    s_emit = s_got || s_err || last;

    // Stream end clears the parse state
    if (last) begin
      s_dpos  = 3'd0;
      s_pbyte = 8'h00;
      s_phase = PH_NORMAL;
      s_idx   = '0;
      s_cand  = 1'b0;
      s_mode  = start_q;
    end
  end

  // Next state
  always_comb begin
    start_d = start_q;
    mode_d  = mode_q;
    phase_d = phase_q;
    dpos_d  = dpos_q;
    pbyte_d = pbyte_q;
    idx_d   = idx_q;
    cand_d  = cand_q;
    err_d   = err_q;
    if (pop_o && !err_q) begin
      mode_d  = s_mode;
      phase_d = s_phase;
      dpos_d  = s_dpos;
      pbyte_d = s_pbyte;
      idx_d   = s_idx;
      cand_d  = s_cand;
      err_d   = s_err;
    end
    if (cfg_valid_i) begin
      start_d = hbt_mode_e'(cfg_data_i);
      mode_d  = hbt_mode_e'(cfg_data_i);
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop_o && !err_q && s_emit) begin
      out_valid_d           = 1'b1;
      out_data_d.byte_valid = s_got;
      out_data_d.out_byte   = s_byte;
      out_data_d.error_flag = s_err;
      out_data_d.error_kind = s_err ? s_kind : ERR_CMD_IN_BYTE;
      out_data_d.stream_end = last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= MD_HEX;
      mode_q      <= MD_HEX;
      phase_q     <= PH_NORMAL;
      dpos_q      <= 3'd0;
      pbyte_q     <= 8'h00;
      idx_q       <= '0;
      cand_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q     <= start_d;
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      dpos_q      <= dpos_d;
      pbyte_q     <= pbyte_d;
      idx_q       <= idx_d;
      cand_q      <= cand_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

### rtl/core/hex_binary_text_to_bytes_top.sv
// Top level of the hex/binary text-to-bytes converter.
// Depends on hbt_pkg, hbt_front, hbt_queue and hbt_back.
//
// Converts a stream of text characters, one per transfer, into bytes. Hex mode
// packs two digits per byte, binary mode eight; '.format hex' and '.format binary'
// select the high-first modes, the same commands with a '_little' suffix the
// low-first modes, ';' starts a comment to end of line, and whitespace is skipped.
// The block takes one character per clock while the output is not stalled; a character
// is written into the queue when accepted, and the parser step loads its result into
// the output register when the character is popped from the queue head. The queue of
// QueueDepth entries between the classifier and the parser absorbs output stalls. The
// first error is reported once and silences the block until reset. The user must write
// the mode register through the cfg channel only while no character is in flight;
// the block itself does not enforce it.
module hex_binary_text_to_bytes_top
  import hbt_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  hbt_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output hbt_out_t   out_data_o
);

  hbt_q_status_t q_status;
  hbt_item_t     push_item, head_item;
  logic          push, pop;

  assign cfg_ready_o = 1'b1;

  hbt_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (push_item)
  );

  hbt_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  hbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head_item),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A reported error silences all later results
  a_err_silences: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.error_flag |=> !out_valid_o)
    else $error("result delivered after an error");

  // A result carries a byte, an error or the stream end, never byte and error together
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_valid || out_data_o.error_flag ||
                     out_data_o.stream_end) &&
                    !(out_data_o.byte_valid && out_data_o.error_flag))
    else $error("malformed result");

  // Unused fields are zero
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_valid || out_data_o.out_byte == 8'h00) &&
                    (out_data_o.error_flag || out_data_o.error_kind == 2'd0))
    else $error("unused result field not cleared");

endmodule

### tb/sv/testbench.sv
// Testbench for hex_binary_text_to_bytes_top: random text streams with an inline
// converter predictor and in-order checking of every result transfer.
// Depends on hbt_pkg and the converter RTL.
module testbench;
  import hbt_pkg::*;

  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned MaxCycles     = 1_000_000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DrainLimit    = 20_000;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 220;

  // Converter state as the predictor tracks it
  typedef struct {
    hbt_mode_e   start;
    hbt_mode_e   mode;
    logic [2:0]  pos;
    logic [7:0]  part;
    hbt_phase_e  phase;
    int unsigned idx;
    bit          cand;
    bit          latched;
  } parser_state_t;

  // Predicts results of accepted characters and checks them in order
  class text_byte_scoreboard;
    parser_state_t st;
    hbt_out_t      pending_results[$];
    int unsigned   failures;
    string hex_short = "format hex";
    string bin_short = "format binary";
    string hex_long  = {"format hex", "_little"};
    string bin_long  = {"format binary", "_little"};

    function new();
      st.start   = MD_HEX;
      st.mode    = MD_HEX;
      st.pos     = '0;
      st.part    = '0;
      st.phase   = PH_NORMAL;
      st.idx     = 0;
      st.cand    = 1'b0;
      st.latched = 1'b0;
      failures   = 0;
    endfunction

    function void set_start(hbt_mode_e m);
      st.start = m;
      st.mode  = m;
    endfunction

    function int unsigned short_len(bit cand);
      return cand ? bin_short.len() : hex_short.len();
    endfunction

    // Ordinary text; returns 1 when a byte completes
    function bit plain_char(inout parser_state_t s, input logic [7:0] c,
                            inout logic [7:0] b, inout bit has_err, inout hbt_err_e err);
      logic [7:0]  v;
      int unsigned shift;
      if (c == ChSpace || c == ChNl || c == ChTab) return 1'b0;
      if (c == ChDot) begin
        if (s.pos != 0) begin
          has_err = 1'b1;
          err     = ERR_CMD_IN_BYTE;
          return 1'b0;
        end
        s.phase = PH_COMMAND;
        s.idx   = 0;
        s.cand  = 1'b0;
        return 1'b0;
      end
      if (c == ChSemi) begin
        s.phase = PH_COMMENT;
        return 1'b0;
      end
      // hex digits, two nibbles per byte
      if (s.mode == MD_HEX || s.mode == MD_HEX_LE) begin
        if (c >= "0" && c <= "9") v = c - "0";
        else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
        else begin
          has_err = 1'b1;
          err     = ERR_BAD_CHAR;
          return 1'b0;
        end
        s.pos = {2'b00, s.pos[0]};
        if (s.mode == MD_HEX) shift = s.pos[0] ? 0 : 4;
        else shift = s.pos[0] ? 4 : 0;
        s.part = s.part | (v << shift);
        if (s.pos[0]) begin
          b      = s.part;
          s.part = '0;
          s.pos  = '0;
          return 1'b1;
        end
        s.pos = 3'd1;
        return 1'b0;
      end
      // binary digits, eight per byte
      if (c != "0" && c != "1") begin
        has_err = 1'b1;
        err     = ERR_BAD_CHAR;
        return 1'b0;
      end
      v = {7'b0, c[0]};
      shift = (s.mode == MD_BIN) ? 7 - s.pos : s.pos;
      s.part = s.part | (v << shift);
      if (s.pos == 3'd7) begin
        b      = s.part;
        s.part = '0;
        s.pos  = '0;
        return 1'b1;
      end
      s.pos = s.pos + 3'd1;
      return 1'b0;
    endfunction

    // One character inside a dot command
    function bit command_char(inout parser_state_t s, input logic [7:0] c,
                              inout logic [7:0] b, inout bit has_err, inout hbt_err_e err);
      int unsigned k;
      string       cmd;
      k = s.idx;
      if (k == CandPos) s.cand = (c == ChLowB);
      cmd = s.cand ? bin_long : hex_long;
      // short form complete, anything but '_' ends it
      if (k == short_len(s.cand) && c != ChUnder) begin
        if (s.cand) s.mode = MD_BIN;
        else s.mode = MD_HEX;
        s.phase = PH_NORMAL;
        s.idx   = 0;
        return plain_char(s, c, b, has_err, err);
      end
      if (k < cmd.len() && c == cmd[k]) begin
        s.idx = k + 1;
        if (s.idx == cmd.len()) begin
          if (s.cand) s.mode = MD_BIN_LE;
          else s.mode = MD_HEX_LE;
          s.phase = PH_NORMAL;
          s.idx   = 0;
        end
        return 1'b0;
      end
      has_err = 1'b1;
      if (k < short_len(s.cand)) err = ERR_BAD_CMD;
      else err = ERR_BAD_CHAR;
      return 1'b0;
    endfunction

    // Full step for one character; returns 1 when a result is due
    function bit convert_char(inout parser_state_t s, input logic [7:0] c, input bit last,
                              output hbt_out_t res);
      logic [7:0] b;
      bit         got;
      bit         has_err;
      hbt_err_e   err;
      res     = '0;
      b       = '0;
      got     = 1'b0;
      has_err = 1'b0;
      err     = ERR_CMD_IN_BYTE;
      if (s.latched) return 1'b0;
      case (s.phase)
        PH_COMMENT: begin
          if (c == ChNl) s.phase = PH_NORMAL;
        end
        PH_COMMAND: got = command_char(s, c, b, has_err, err);
        default:    got = plain_char(s, c, b, has_err, err);
      endcase
      // text ends inside a command
      if (!has_err && last && s.phase == PH_COMMAND) begin
        if (s.idx == short_len(s.cand)) begin
          if (s.cand) s.mode = MD_BIN;
          else s.mode = MD_HEX;
        end else begin
          has_err = 1'b1;
          if (s.idx < short_len(s.cand)) err = ERR_BAD_CMD;
          else err = ERR_BAD_CHAR;
        end
      end
      if (has_err) begin
        s.latched = 1'b1;
        got       = 1'b0;
      end
      if (!got && !has_err && !last) return 1'b0;
      res.byte_valid = got;
      res.out_byte   = got ? b : '0;
      res.error_flag = has_err;
      res.error_kind = has_err ? err : '0;
      res.stream_end = last;
      if (last) begin
        s.pos   = '0;
        s.part  = '0;
        s.phase = PH_NORMAL;
        s.idx   = 0;
        s.cand  = 1'b0;
        s.mode  = s.start;
      end
      return 1'b1;
    endfunction

    function void take_char(logic [7:0] c, bit last);
      hbt_out_t r;
      if (convert_char(st, c, last, r)) pending_results.push_back(r);
    endfunction

    // Dry run on a copy of the state
    function bit would_fail(logic [7:0] c, bit last);
      parser_state_t tmp;
      hbt_out_t      r;
      tmp = st;
      void'(convert_char(tmp, c, last, r));
      return r.error_flag;
    endfunction

    // Character that continues the command in progress
    function logic [7:0] next_cmd_char();
      string cmd;
      cmd = st.cand ? bin_long : hex_long;
      return cmd[st.idx];
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(hbt_out_t got);
      hbt_out_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: byte_valid %0b out_byte %02h error_flag %0b kind %0d end %0b",
               got.byte_valid, got.out_byte, got.error_flag, got.error_kind, got.stream_end);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      compare("out_byte", want.out_byte, got.out_byte);
      compare("error_flag", 8'(want.error_flag), 8'(got.error_flag));
      compare("error_kind", 8'(want.error_kind), 8'(got.error_kind));
      compare("stream_end", 8'(want.stream_end), 8'(got.stream_end));
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [1:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  hbt_in_t    in_data_i   = '0;
  logic       out_ready_i = 1'b1;
  logic       cfg_ready_o;
  logic       in_ready_o;
  logic       out_valid_o;
  hbt_out_t   out_data_o;

  text_byte_scoreboard conv;
  bit          calm;
  int unsigned items;
  string       hex_digits   = "0123456789abcdefABCDEF";
  string       cmd_forms[4] = '{"format hex", {"format hex", "_little"}, "format binary",
                                {"format binary", "_little"}};
  hbt_mode_e   sweep[4]     = '{MD_BIN_LE, MD_BIN, MD_HEX_LE, MD_HEX};

  hex_binary_text_to_bytes_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Idle gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_digit();
    if (conv.st.mode == MD_HEX || conv.st.mode == MD_HEX_LE)
      return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
    return $urandom_range(0, 1) ? "1" : "0";
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 2))
      0: return ChSpace;
      1: return ChTab;
      default: return ChNl;
    endcase
  endfunction

  // One character transfer; valid stays high afterwards
  task automatic drive(input logic [7:0] c, input bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= '{text_char: c, last_char: last};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    conv.take_char(c, last);
    items++;
  endtask

  // Keep the stream error-free: finish a command in progress, drop other bad characters
  task automatic feed(input logic [7:0] c, input bit last);
    logic [7:0] ch;
    bit         lst;
    ch  = c;
    lst = last;
    if (conv.would_fail(ch, lst)) begin
      if (conv.st.phase != PH_COMMAND) return;
      ch  = conv.next_cmd_char();
      lst = 1'b0;
    end
    drive(ch, lst);
  endtask

  task automatic send_text(input string s, input bit last_at_end, input bit raw);
    for (int i = 0; i < s.len(); i++) begin
      if (raw) drive(s[i], last_at_end && i == s.len() - 1);
      else feed(s[i], last_at_end && i == s.len() - 1);
    end
  endtask

  // Sender holds off until every expected result is out
  task automatic hold_until_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (conv.pending() != 0);
  endtask

  task automatic set_start_mode(input hbt_mode_e m);
    hold_until_idle();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    conv.set_start(m);
  endtask

  // One random token of text
  task automatic gen_token();
    int unsigned r;
    string       text;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      repeat ($urandom_range(1, 8)) feed(pick_digit(), 1'b0);
    end else if (r < 55) begin
      feed(pick_space(), 1'b0);
    end else if (r < 63) begin
      feed(ChSemi, 1'b0);
      repeat ($urandom_range(0, 5)) feed(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 5) == 0) feed(8'($urandom_range(0, 255)), 1'b1);
      else feed(ChNl, 1'b0);
    end else if (r < 75) begin
      text = {".", cmd_forms[$urandom_range(0, 3)]};
      if ($urandom_range(0, 9) == 0) text = text.substr(0, $urandom_range(1, text.len() - 2));
      send_text(text, $urandom_range(0, 7) == 0, 1'b0);
    end else if (r < 82) begin
      feed(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    end else if (r < 92) begin
      feed($urandom_range(0, 1) ? pick_digit() : pick_space(), 1'b1);
    end else begin
      feed(pick_space(), 1'b0);
    end
  endtask

  // Close the stream cleanly, then cause one error; nothing may follow it
  task automatic provoke_error();
    logic [7:0] bad;
    while (conv.st.phase != PH_NORMAL) feed(ChNl, 1'b0);
    feed(ChNl, 1'b1);
    case ($urandom_range(0, 5))
      0: send_text("1.", 1'b0, 1'b1);
      1: send_text(".fx", 1'b0, 1'b1);
      2: send_text(".format hex_z", 1'b0, 1'b1);
      3: send_text(".form", 1'b1, 1'b1);
      4: send_text(".format binary_", 1'b1, 1'b1);
      default: begin
        case ($urandom_range(0, 3))
          0: bad = 8'h00;
          1: bad = 8'h0d;
          2: bad = 8'($urandom_range(128, 255));
          default: bad = "g";
        endcase
        drive(bad, 1'($urandom_range(0, 1)));
      end
    endcase
    repeat (8) drive(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) conv.check_result(out_data_o);
  end

  // Receiver stalls
  initial begin : ready_gen
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
      end else if (out_ready_i) begin
        hold_left = pick_gap();
        if (hold_left != 0) out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        hold_left = $urandom_range(0, 12);
      end
    end
  end

  // Stretches without any idling
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk_i);
      calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Run limit
  initial begin
    #(2 * ClkHalf * MaxCycles);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned target;
    hbt_mode_e   m;
    conv = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: skipped characters, byte extremes, comment with odd bytes,
    // partial byte dropped at stream end, stream ending on a complete short command
    set_start_mode(MD_HEX);
    send_text("\t 00\nfF;", 1'b0, 1'b1);
    drive(8'hff, 1'b0);
    drive(ChDot, 1'b0);
    drive(8'h00, 1'b0);
    drive(ChNl, 1'b0);
    drive("9", 1'b1);
    send_text(".format hex", 1'b1, 1'b1);

    // random phases, each under its own start mode
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 4) m = sweep[p];
      else m = hbt_mode_e'($urandom_range(0, 3));
      set_start_mode(m);
      target = items + ItemsPerPhase / 2;
      while (items < target) gen_token();
      if (p == 0 || $urandom_range(0, 2) == 0) hold_until_idle();
      target = items + ItemsPerPhase / 2;
      while (items < target) gen_token();
    end

    provoke_error();

    // drain and settle
    in_valid_i <= 1'b0;
    for (int i = 0; i < DrainLimit && conv.pending() != 0; i++) @(posedge clk_i);
    repeat (4 * SettleCycles) @(posedge clk_i);
    if (conv.pending() != 0) begin
      $error("%0d expected results never arrived", conv.pending());
      conv.failures++;
    end
    if (conv.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
